@@ rtl/utd_pkg.sv @@
// ----------------------------------------------------------------------------
// utd_pkg
// Types, constants and lead byte decode shared by the UTF-8 text detector.
// ----------------------------------------------------------------------------
package utd_pkg;

  localparam logic [7:0] ContMask      = 8'hC0;
  localparam logic [7:0] ContTag       = 8'h80;
  localparam logic [7:0] BadLeadMask   = 8'hFE;
  localparam logic [7:0] ConfidentInit = 8'd10;
  localparam logic [7:0] CountMax      = 8'hFF;

  typedef struct packed {
    logic [2:0] pending;
    logic [7:0] count;
    logic       decided;
    logic       verdict;
  } utd_state_t;

  function automatic logic [2:0] lead_continuations(input logic [7:0] b);
    logic [2:0] n;
    if (b >= 8'hFC) begin
      n = 3'd5;
    end else if (b >= 8'hF8) begin
      n = 3'd4;
    end else if (b >= 8'hF0) begin
      n = 3'd3;
    end else if (b >= 8'hE0) begin
      n = 3'd2;
    end else begin
      n = 3'd1;
    end
    return n;
  endfunction

endpackage

@@ rtl/utd_step.sv @@
// ----------------------------------------------------------------------------
// utd_step
// Next string state and end-of-string verdict for one byte.
// ----------------------------------------------------------------------------
module utd_step (
  input  utd_pkg::utd_state_t state_i,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  input  logic [7:0]          confident_count_i,
  output utd_pkg::utd_state_t state_o,
  output logic                looks_utf8_o,
  output logic [7:0]          multibyte_chars_o
);

  utd_pkg::utd_state_t upd;
  logic [7:0]          cnt_inc;
  logic                is_cont;

  assign is_cont = (data_byte_i & utd_pkg::ContMask) == utd_pkg::ContTag;
  assign cnt_inc = (state_i.count == utd_pkg::CountMax) ? state_i.count
                                                        : state_i.count + 8'd1;

  always_comb begin
    upd = state_i;
    if (!state_i.decided) begin
      if (state_i.pending != 3'd0) begin
        if (!is_cont) begin
          upd.decided = 1'b1;
          upd.verdict = 1'b0;
        end else begin
          upd.pending = state_i.pending - 3'd1;
          if (state_i.pending == 3'd1) begin
            upd.count = cnt_inc;
            if (cnt_inc > confident_count_i) begin
              upd.decided = 1'b1;
              upd.verdict = 1'b1;
            end
          end
        end
      end else if (data_byte_i[7]) begin
        if (((data_byte_i & utd_pkg::ContMask) == utd_pkg::ContMask) &&
            ((data_byte_i & utd_pkg::BadLeadMask) != utd_pkg::BadLeadMask)) begin
          upd.pending = utd_pkg::lead_continuations(data_byte_i);
        end else begin
          upd.decided = 1'b1;
          upd.verdict = 1'b0;
        end
      end
    end
  end

  always_comb begin
    if (upd.decided) begin
      looks_utf8_o = upd.verdict;
    end else if (upd.pending != 3'd0) begin
      looks_utf8_o = 1'b0;
    end else begin
      looks_utf8_o = upd.count != 8'd0;
    end
  end

  assign multibyte_chars_o = upd.count;
  assign state_o           = last_byte_i ? '0 : upd;

endmodule

@@ rtl/utf8_text_detector.sv @@
// ----------------------------------------------------------------------------
// utf8_text_detector
// Streams string bytes and gives one UTF-8 verdict per string on its last byte.
// ----------------------------------------------------------------------------
// An accepted last byte passes through the input register, then its result is registered.
// Throughput: one byte per cycle, set by the state update; a last
// byte waits in the input register only while a stalled result is held.
// Reset clears the string state, empties both registers and loads a
// threshold of 10.
module utf8_text_detector (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       looks_utf8_o,
  output logic [7:0] multibyte_chars_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] confident_count_i
);

  logic                in_fire;
  logic                step_fire;
  logic                advance;
  logic                in_valid_q, in_valid_d;
  logic [7:0]          byte_q;
  logic                last_q;
  logic [7:0]          conf_q;
  utd_pkg::utd_state_t state_q, state_d;
  logic                verdict_d;
  logic [7:0]          count_d;
  logic                out_valid_q, out_valid_d;
  logic                looks_q;
  logic [7:0]          chars_q;

  assign cfg_ready_o = 1'b1;
  assign advance     = !last_q || !out_valid_q || !out_stall_i;
  assign step_fire   = in_valid_q && advance;
  assign in_stall_o  = in_valid_q && !advance;
  assign in_fire     = in_valid_i && !in_stall_o;

  utd_step u_step (
    .state_i          (state_q),
    .data_byte_i      (byte_q),
    .last_byte_i      (last_q),
    .confident_count_i(conf_q),
    .state_o          (state_d),
    .looks_utf8_o     (verdict_d),
    .multibyte_chars_o(count_d)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (step_fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step_fire && last_q) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
      conf_q      <= utd_pkg::ConfidentInit;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (step_fire) begin
        state_q <= state_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        conf_q <= confident_count_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
    if (step_fire && last_q) begin
      looks_q <= verdict_d;
      chars_q <= count_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign looks_utf8_o      = looks_q;
  assign multibyte_chars_o = chars_q;

  a_pending_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.pending <= 3'd5)
    else $error("pending continuation count out of range");

  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_fire && last_q) |=> (state_q == '0))
    else $error("string state not cleared after last beat");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(step_fire && last_q))
    else $error("result raised without a last beat");

  a_decided_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.decided && !(step_fire && last_q)) |=> $stable(state_q.count))
    else $error("count changed after verdict was fixed");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && last_q && out_valid_q))
    else $error("input stalled without a blocked last beat");

endmodule
